>>> hdl/lbba_pkg.sv
// ----------------------------------------------------------------------------
// lbba_pkg
// shared op codes, divider sizing and controller/datapath handshake types
// ----------------------------------------------------------------------------
`default_nettype none

package lbba_pkg;

    localparam int BYTE_W = 8;
    localparam int OP_W   = 4;
    localparam int USER_W = OP_W + 1;

    localparam logic [OP_W-1:0] OP_AND     = 4'd0;
    localparam logic [OP_W-1:0] OP_OR      = 4'd1;
    localparam logic [OP_W-1:0] OP_XOR     = 4'd2;
    localparam logic [OP_W-1:0] OP_NAND    = 4'd3;
    localparam logic [OP_W-1:0] OP_NOR     = 4'd4;
    localparam logic [OP_W-1:0] OP_SATADD  = 4'd5;
    localparam logic [OP_W-1:0] OP_SATSUB  = 4'd6;
    localparam logic [OP_W-1:0] OP_WRAPADD = 4'd7;
    localparam logic [OP_W-1:0] OP_WRAPSUB = 4'd8;
    localparam logic [OP_W-1:0] OP_MUL     = 4'd9;
    localparam logic [OP_W-1:0] OP_MULOVER = 4'd10;
    localparam logic [OP_W-1:0] OP_DIV     = 4'd11;
    localparam logic [OP_W-1:0] OP_DIVOVER = 4'd12;

    localparam int DIVIDEND_W     = 2 * BYTE_W;
    localparam int BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES     = DIVIDEND_W / BITS_PER_CYCLE;
    localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);

    typedef struct packed {
        logic accept;
        logic emit_now;
        logic div_step;
        logic div_finish;
        logic emit_acc;
    } lbba_cmd_t;

    typedef struct packed {
        logic item_is_div;
        logic out_busy;
    } lbba_status_t;

endpackage

`default_nettype wire

>>> hdl/lbba_ctrl.sv
// ----------------------------------------------------------------------------
// lbba_ctrl
// sequencer: accepts beats, runs the divider steps and schedules output loads
// ----------------------------------------------------------------------------
`default_nettype none

module lbba_ctrl
    import lbba_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tlast,
    output logic              s_axis_tready,
    input  lbba_status_t      status,
    output lbba_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 last_pending_reg, last_pending_next;
    logic                 accept;

    assign s_axis_tready = (state_reg == ST_IDLE)
                           && !(s_axis_tlast && status.out_busy && !status.item_is_div);
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        last_pending_next = last_pending_reg;
        cmd               = '0;
        cmd.accept        = accept;
        cmd.emit_now      = accept && s_axis_tlast && !status.item_is_div;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.item_is_div)
                begin
                    state_next        = ST_DIV;
                    cnt_next          = '0;
                    last_pending_next = s_axis_tlast;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.div_finish = 1'b1;
                state_next     = last_pending_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_acc = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cnt_reg          <= '0;
            last_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            last_pending_reg <= last_pending_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lbba_datapath.sv
// ----------------------------------------------------------------------------
// lbba_datapath
// accumulator, combinational blend ops, radix-4 restoring divider, output register
// ----------------------------------------------------------------------------
`default_nettype none

module lbba_datapath
    import lbba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,
    input  wire logic [USER_W-1:0] s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata,
    input  lbba_cmd_t              cmd,
    output lbba_status_t           status
);

    logic [BYTE_W-1:0]     acc_reg, acc_next;
    logic [BYTE_W-1:0]     b_reg;
    logic                  wrap_reg;
    logic [BYTE_W-1:0]     rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_data_reg;

    logic                  first_layer;
    logic [OP_W-1:0]       op;
    logic [BYTE_W-1:0]     a, b;
    logic [BYTE_W:0]       sum9;
    logic [DIVIDEND_W-1:0] prod, prod_adj, dividend;
    logic [BYTE_W-1:0]     blend;
    logic [BYTE_W-1:0]     div_result;
    logic [BYTE_W+DIVIDEND_W-1:0] step1, step2;

    function automatic logic [BYTE_W+DIVIDEND_W-1:0] div_bit(
        input logic [BYTE_W-1:0]     rem,
        input logic [DIVIDEND_W-1:0] quo,
        input logic [BYTE_W-1:0]     den
    );
        logic [BYTE_W:0]   trial;
        logic [BYTE_W:0]   diff;
        logic              take;
        trial = {rem, quo[DIVIDEND_W-1]};
        diff  = trial - {1'b0, den};
        take  = trial >= {1'b0, den};
        return {take ? diff[BYTE_W-1:0] : trial[BYTE_W-1:0],
                quo[DIVIDEND_W-2:0], take};
    endfunction

    assign first_layer = s_axis_tuser[0];
    assign op          = s_axis_tuser[USER_W-1:1];
    assign a           = acc_reg;
    assign b           = s_axis_tdata;

    assign status.item_is_div = !first_layer && (op == OP_DIV || op == OP_DIVOVER);
    assign status.out_busy    = out_valid_reg && !m_axis_tready;

    assign sum9     = {1'b0, a} + {1'b0, b};
    assign prod     = {{BYTE_W{1'b0}}, a} * {{BYTE_W{1'b0}}, b};
    assign prod_adj = prod + {{BYTE_W{1'b0}}, prod[DIVIDEND_W-1:BYTE_W]}
                      + DIVIDEND_W'(1);
    assign dividend = {a, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, a};

    always_comb
    begin
        case (op)
            OP_AND:     blend = a & b;
            OP_OR:      blend = a | b;
            OP_XOR:     blend = a ^ b;
            OP_NAND:    blend = ~(a & b);
            OP_NOR:     blend = ~(a | b);
            OP_SATADD:  blend = sum9[BYTE_W] ? {BYTE_W{1'b1}} : sum9[BYTE_W-1:0];
            OP_SATSUB:  blend = (a < b) ? '0 : a - b;
            OP_WRAPADD: blend = a + b;
            OP_WRAPSUB: blend = a - b;
            OP_MUL,
            OP_MULOVER: blend = prod_adj[DIVIDEND_W-1:BYTE_W];
            default:    blend = a;
        endcase
    end

    assign step1 = div_bit(rem_reg, quo_reg, b_reg);
    assign step2 = div_bit(step1[BYTE_W+DIVIDEND_W-1:DIVIDEND_W],
                           step1[DIVIDEND_W-1:0], b_reg);

    always_comb
    begin
        if (b_reg == '0)
        begin
            div_result = {BYTE_W{1'b1}};
        end
        else if (wrap_reg)
        begin
            div_result = quo_reg[BYTE_W-1:0];
        end
        else if (|quo_reg[DIVIDEND_W-1:BYTE_W])
        begin
            div_result = {BYTE_W{1'b1}};
        end
        else
        begin
            div_result = quo_reg[BYTE_W-1:0];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.accept && !status.item_is_div)
        begin
            acc_next = first_layer ? b : blend;
        end
        else if (cmd.div_finish)
        begin
            acc_next = div_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cmd.emit_now || cmd.emit_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_now || cmd.emit_acc)
        begin
            out_data_reg <= acc_next;
        end
        if (cmd.accept && status.item_is_div)
        begin
            b_reg    <= b;
            wrap_reg <= (op == OP_DIVOVER);
            rem_reg  <= '0;
            quo_reg  <= dividend;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= step2[BYTE_W+DIVIDEND_W-1:DIVIDEND_W];
            quo_reg <= step2[DIVIDEND_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> hdl/layer_byte_blend_accumulator.sv
// ----------------------------------------------------------------------------
// layer_byte_blend_accumulator
// folds a run of layer bytes for one pixel into one blended gray byte
// ----------------------------------------------------------------------------
// slave stream carries one layer per beat: tdata is the layer byte, tuser holds
// the first-layer flag and the blend op, tlast marks the last layer of a pixel.
// a beat with the first-layer flag loads the accumulator; other beats blend
// into it. on the last layer one beat with the pixel byte leaves on the master
// stream, held in an output register.
// logic, add, subtract and multiply ops take one cycle per beat, so such beats
// stream back to back unless held as below; a last-layer result appears in the
// cycle after its beat. the two divide ops run a restoring divider, two
// quotient bits per cycle over a 16-bit dividend; no new beat is taken until
// the divide and finish steps (and, on a last beat, the output load) are done.
// reset clears the accumulator to zero and empties the output register.
// while a result waits on a stalled receiver, non-last and divide beats are
// still taken; other last beats wait until the output register can be reloaded.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_byte_blend_accumulator
    import lbba_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,  // layer_value
    input  wire logic              s_axis_tlast,
    input  wire logic [USER_W-1:0] s_axis_tuser,  // first_layer, op
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata   // pixel_value
);

    lbba_cmd_t    cmd;
    lbba_status_t status;

    lbba_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    lbba_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

>>> dv/layer_byte_blend_accumulator_tb.sv
// ----------------------------------------------------------------------------
// layer_byte_blend_accumulator_tb
// self-checking bench for the layer blend accumulator
// ----------------------------------------------------------------------------
// layer beats are queued up front and fed to the slave stream by a clocked
// driver. an in-bench blend predictor follows every accepted beat and keeps
// the expected pixel bytes, which the monitor compares in order against the
// master stream. both sides stall at random, the receiver also holds off for
// a long stretch so the block backs up, and a quiet window runs without gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_byte_blend_accumulator_tb
    import lbba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd13;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
    localparam int RANDOM_BEATS = 600;
    localparam int QUIET_FROM   = 1000;
    localparam int QUIET_TO     = 1600;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 150;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic              first;
        logic [BYTE_W-1:0] value;
        logic [OP_W-1:0]   op;
        logic              last;
    } layer_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata = '0;  // layer_value
    logic              s_axis_tlast = 1'b0;
    logic [USER_W-1:0] s_axis_tuser = '0;  // first_layer, op
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [BYTE_W-1:0] m_axis_tdata;       // pixel_value

    layer_beat_t       pending_layers[$];
    logic [BYTE_W-1:0] expected_pixels[$];
    logic [BYTE_W-1:0] acc_byte = '0;
    logic [BYTE_W-1:0] want_pixel;
    layer_beat_t       next_layer;
    logic              beat_taken = 1'b0;
    logic              rx_hold = 1'b0;
    int unsigned       cycle_cnt = 0;
    int unsigned       mismatch_count = 0;

    layer_byte_blend_accumulator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    function automatic logic [BYTE_W-1:0] blend_byte(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [OP_W-1:0]   op);
        logic [15:0] prod;
        logic [15:0] quot;
        prod = {8'd0, a} * {8'd0, b};
        quot = (b == '0) ? 16'hFFFF : ({8'd0, a} * 16'd255) / {8'd0, b};
        case (op)
            OP_AND:     return a & b;
            OP_OR:      return a | b;
            OP_XOR:     return a ^ b;
            OP_NAND:    return ~(a & b);
            OP_NOR:     return ~(a | b);
            OP_SATADD:  return ({1'b0, a} + {1'b0, b} > 9'd255) ? 8'hFF : a + b;
            OP_SATSUB:  return (a < b) ? 8'h00 : a - b;
            OP_WRAPADD: return a + b;
            OP_WRAPSUB: return a - b;
            OP_MUL,
            OP_MULOVER: return 8'(prod / 16'd255);
            OP_DIV:     return (b == '0 || quot > 16'd255) ? 8'hFF : quot[7:0];
            OP_DIVOVER: return (b == '0) ? 8'hFF : quot[7:0];
            default:    return a;
        endcase
    endfunction

    function automatic logic stall_roll();
        if (cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    task automatic add_layer(input logic first, input logic [BYTE_W-1:0] value,
                             input logic [OP_W-1:0] op, input logic last);
        layer_beat_t beat;
        beat.first = first;
        beat.value = value;
        beat.op    = op;
        beat.last  = last;
        pending_layers.push_back(beat);
    endtask

    function automatic logic [BYTE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'(1 << $urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    // monitor and predictor
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n)
        begin
            beat_taken <= 1'b0;
        end
        else
        begin
            beat_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel_value: unexpected beat, got %0d", m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    if (m_axis_tdata !== want_pixel)
                    begin
                        $error("pixel_value: expected %0d, got %0d", want_pixel,
                               m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser[0])
                    acc_byte = s_axis_tdata;
                else
                    acc_byte = blend_byte(acc_byte, s_axis_tdata, s_axis_tuser[USER_W-1:1]);
                if (s_axis_tlast)
                    expected_pixels.push_back(acc_byte);
            end
        end
    end

    // slave-side driver
    always @(negedge clk)
    begin
        if (rst_n && (beat_taken || !s_axis_tvalid))
        begin
            if (pending_layers.size() != 0 && !stall_roll())
            begin
                next_layer = pending_layers.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_layer.value;
                s_axis_tuser  <= {next_layer.op, next_layer.first};
                s_axis_tlast  <= next_layer.last;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // master-side receiver
    always @(negedge clk)
    begin
        m_axis_tready <= rst_n && !rx_hold && !stall_roll();
    end

    // long receiver hold-off so the output register stays full
    initial
    begin
        @(posedge rst_n);
        repeat (HOLD_AFTER) @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned queued;
        int unsigned depth;
        int unsigned kind;

        // blend straight after reset, then first and last in one beat
        add_layer(1'b0, 8'hFF, OP_SATADD, 1'b1);
        add_layer(1'b1, 8'h00, OP_AND, 1'b1);
        // divide by zero on both divide forms
        add_layer(1'b0, 8'h00, OP_DIV, 1'b1);
        add_layer(1'b0, 8'h00, OP_DIVOVER, 1'b1);
        add_layer(1'b0, 8'h01, OP_DIV, 1'b1);
        add_layer(1'b1, 8'hFF, OP_DIVOVER, 1'b0);
        add_layer(1'b0, 8'h01, OP_DIVOVER, 1'b1);
        add_layer(1'b0, 8'hFF, OP_MUL, 1'b1);
        add_layer(1'b0, 8'h80, OP_MULOVER, 1'b1);
        add_layer(1'b1, 8'hC3, OP_AND, 1'b0);
        add_layer(1'b0, 8'hAA, OP_AND, 1'b1);
        add_layer(1'b0, 8'h0F, OP_OR, 1'b1);
        add_layer(1'b0, 8'hFF, OP_XOR, 1'b1);
        add_layer(1'b0, 8'h3C, OP_NAND, 1'b1);
        add_layer(1'b0, 8'h00, OP_NOR, 1'b1);
        add_layer(1'b0, 8'hFF, OP_SATADD, 1'b1);
        add_layer(1'b0, 8'h7F, OP_WRAPADD, 1'b1);
        add_layer(1'b0, 8'hFF, OP_SATSUB, 1'b1);
        add_layer(1'b0, 8'h01, OP_WRAPSUB, 1'b1);
        add_layer(1'b0, 8'h55, OP_SPARE_LO, 1'b1);
        add_layer(1'b0, 8'hAA, OP_SPARE_HI, 1'b1);
        add_layer(1'b0, 8'hFF, OP_DIV, 1'b1);
        add_layer(1'b0, 8'h00, OP_SATSUB, 1'b1);

        // random pixels, mostly well formed, some noise and headless runs
        queued = 0;
        while (queued < RANDOM_BEATS)
        begin
            kind  = $urandom_range(0, 9);
            depth = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12)
                                                 : $urandom_range(1, 5);
            if (kind == 0)
            begin
                add_layer(1'($urandom), 8'($urandom), 4'($urandom), 1'($urandom));
                queued++;
            end
            else
            begin
                for (int i = 0; i < depth; i++)
                    add_layer(i == 0 && kind != 1, pick_value(),
                              4'($urandom_range(0, 15)), i == depth - 1);
                queued += depth;
            end
        end
        add_layer(1'b1, 8'($urandom), OP_AND, 1'b1);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_layers.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
